FILE: hw/rtl/rna_pkg.sv
package rna_pkg;

	// fixed field widths of the stream payload
	localparam int FIELD_BITS     = 16;
	localparam int NUM_BITS       = 33;
	localparam int DEN_BITS       = 32;
	localparam int INT_BITS       = 17;
	localparam int FUNC_BITS      = 3;
	localparam int IN_TDATA_BITS  = 72;
	localparam int OUT_TDATA_BITS = 88;

	localparam int DEF_VALUE_BITS = 16;
	localparam int QUEUE_DEPTH    = 2;

	// operation select codes
	localparam logic [FUNC_BITS-1:0] FUNC_MAKE       = 3'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_ADD        = 3'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_ADD_REDUCE = 3'd2;
	localparam logic [FUNC_BITS-1:0] FUNC_MUL        = 3'd3;
	localparam logic [FUNC_BITS-1:0] FUNC_EQUAL      = 3'd4;
	localparam logic [FUNC_BITS-1:0] FUNC_NOT_EQUAL  = 3'd5;
	localparam logic [FUNC_BITS-1:0] FUNC_TO_INT     = 3'd6;

	// work classes handed from the front to the back
	typedef enum logic [3:0] {
		K_NONE,     // all-zero result
		K_EMPTY,    // empty fraction
		K_INTNEG,   // to_int of an empty or zero-denominator operand
		K_MAKE,
		K_ADD,
		K_ADDR,
		K_MUL,
		K_EQ,
		K_NEQ,
		K_INT
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [FIELD_BITS-1:0] a_num;
		logic [FIELD_BITS-1:0] a_den;
		logic [FIELD_BITS-1:0] b_num;
		logic [FIELD_BITS-1:0] b_den;
	} cmd_t;

	typedef struct packed {
		logic [INT_BITS-1:0] ival;
		logic                flag;
		logic                empty;
		logic [DEN_BITS-1:0] den;
		logic [NUM_BITS-1:0] num;
	} res_t;

endpackage

FILE: hw/rtl/rna_front.sv
module rna_front import rna_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_TDATA_BITS-1:0] s_tdata,
	input  logic [FUNC_BITS-1:0]     s_tuser,
	input  logic                     q_full,
	output logic                     q_push,
	output cmd_t                     q_cmd
);

	localparam logic [FIELD_BITS-1:0] VMASK = (VALUE_BITS >= FIELD_BITS) ? {FIELD_BITS{1'b1}} :
		FIELD_BITS'((64'd1 << VALUE_BITS) - 64'd1);

	logic [FIELD_BITS-1:0] an, ad, bn, bd;
	logic                  ae, be, any_empty;

	assign an = s_tdata[15:0] & VMASK;
	assign ad = s_tdata[31:16] & VMASK;
	assign ae = s_tdata[32];
	assign bn = s_tdata[48:33] & VMASK;
	assign bd = s_tdata[64:49] & VMASK;
	assign be = s_tdata[65];
	assign any_empty = ae || be;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_cmd.a_num = an;
		q_cmd.a_den = ad;
		q_cmd.b_num = bn;
		q_cmd.b_den = bd;
		case (s_tuser)
			FUNC_MAKE:       q_cmd.kind = (ad == '0) ? K_EMPTY : K_MAKE;
			FUNC_ADD:        q_cmd.kind = any_empty ? K_EMPTY : K_ADD;
			FUNC_ADD_REDUCE: q_cmd.kind = any_empty ? K_EMPTY : K_ADDR;
			FUNC_MUL:        q_cmd.kind = any_empty ? K_EMPTY : K_MUL;
			FUNC_EQUAL:      q_cmd.kind = any_empty ? K_NONE : K_EQ;
			FUNC_NOT_EQUAL:  q_cmd.kind = any_empty ? K_NONE : K_NEQ;
			FUNC_TO_INT:     q_cmd.kind = (ae || ad == '0) ? K_INTNEG : K_INT;
			default:         q_cmd.kind = K_NONE;
		endcase
	end

endmodule

FILE: hw/rtl/rna_queue.sv
module rna_queue import rna_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH   // at least 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic full,
	output logic empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: hw/rtl/rna_back.sv
module rna_back import rna_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  cmd_t q_cmd,
	output logic q_pop,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int OPW = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
	localparam int PW  = 2 * OPW;        // product width
	localparam int NW  = PW + 1;         // sum width
	localparam int KW  = $clog2(NW);
	localparam int CW  = $clog2(NW + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_RED  = 6'b000100,
		ST_GCD  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t         state_q;
	kind_t          kind_q;
	logic [OPW-1:0] an_q, ad_q, bn_q, bd_q;
	logic [1:0]     step_q;
	logic [PW-1:0]  prod_q;
	logic [NW-1:0]  x_q, y_q, u_q, v_q, d_q;
	logic [KW-1:0]  k_q;
	logic [NW:0]    rx_q, ry_q;
	logic [CW-1:0]  cnt_q;
	logic           flag_q;
	logic           res_valid_q;
	res_t           res_q;

	logic [OPW-1:0] ma, mb;
	logic [PW-1:0]  mul;
	logic [NW-1:0]  g;
	logic [NW:0]    rx_sh, ry_sh;
	logic           qx, qy;
	logic           out_free;
	res_t           res_d;

	// one shared multiplier, operand pair picked by step
	always_comb begin
		case (step_q)
			2'd0: begin
				ma = an_q;
				mb = (kind_q == K_MUL) ? bn_q : bd_q;
			end
			2'd1: begin
				ma = ad_q;
				mb = (kind_q == K_MUL) ? bd_q : bn_q;
			end
			default: begin
				ma = ad_q;
				mb = bd_q;
			end
		endcase
	end
	assign mul = PW'(ma) * PW'(mb);

	assign g = u_q << k_q;

	// restoring divider, two dividends over a shared divisor
	assign rx_sh = {rx_q[NW-1:0], x_q[NW-1]};
	assign ry_sh = {ry_q[NW-1:0], y_q[NW-1]};
	assign qx    = (rx_sh >= {1'b0, d_q});
	assign qy    = (ry_sh >= {1'b0, d_q});

	assign out_free = !res_valid_q || res_ready;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;

	always_comb begin
		res_d = '0;
		case (kind_q)
			K_EMPTY:  res_d.empty = 1'b1;
			K_INTNEG: res_d.ival = '1;
			K_INT:    res_d.ival = INT_BITS'(x_q[OPW-1:0]);
			K_EQ, K_NEQ: res_d.flag = flag_q;
			K_MAKE, K_ADD, K_ADDR, K_MUL: begin
				res_d.num = NUM_BITS'(x_q);
				res_d.den = DEN_BITS'(y_q[PW-1:0]);
			end
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					kind_q <= q_cmd.kind;
					an_q   <= q_cmd.a_num[OPW-1:0];
					ad_q   <= q_cmd.a_den[OPW-1:0];
					bn_q   <= q_cmd.b_num[OPW-1:0];
					bd_q   <= q_cmd.b_den[OPW-1:0];
					x_q    <= NW'(q_cmd.a_num[OPW-1:0]);
					y_q    <= (q_cmd.kind == K_INT) ? '0 : NW'(q_cmd.a_den[OPW-1:0]);
					d_q    <= NW'(q_cmd.a_den[OPW-1:0]);
					rx_q   <= '0;
					ry_q   <= '0;
				end
			end
			ST_MUL: begin
				prod_q <= mul;
				case (step_q)
					2'd1: x_q <= NW'(prod_q);
					2'd2: begin
						if (kind_q == K_ADD || kind_q == K_ADDR) x_q <= x_q + NW'(prod_q);
						if (kind_q == K_MUL) y_q <= NW'(prod_q);
						flag_q <= (x_q[PW-1:0] == prod_q) ^ (kind_q == K_NEQ);
					end
					2'd3: y_q <= NW'(prod_q);
					default: ;
				endcase
			end
			ST_RED: begin
				u_q <= x_q;
				v_q <= y_q;
				k_q <= '0;
			end
			ST_GCD: begin
				if (u_q == v_q) begin
					d_q  <= g;
					rx_q <= '0;
					ry_q <= '0;
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q > v_q) begin
					u_q <= (u_q - v_q) >> 1;
				end else begin
					v_q <= (v_q - u_q) >> 1;
				end
			end
			ST_DIV: begin
				rx_q <= qx ? rx_sh - {1'b0, d_q} : rx_sh;
				ry_q <= qy ? ry_sh - {1'b0, d_q} : ry_sh;
				x_q  <= {x_q[NW-2:0], qx};
				y_q  <= {y_q[NW-2:0], qy};
			end
			default: ;
		endcase
		if (state_q == ST_OUT && out_free) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) res_valid_q <= 1'b1;
			else if (res_ready)                res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					cnt_q  <= '0;
					if (!q_empty) begin
						case (q_cmd.kind)
							K_MAKE:  state_q <= ST_RED;
							K_INT:   state_q <= ST_DIV;
							K_ADD, K_ADDR, K_MUL, K_EQ, K_NEQ: state_q <= ST_MUL;
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd2 && (kind_q == K_EQ || kind_q == K_NEQ))
						state_q <= ST_OUT;
					else if (step_q == 2'd3)
						state_q <= (kind_q == K_ADDR) ? ST_RED : ST_OUT;
				end
				ST_RED: begin
					// a zero on either side keeps the pair as is
					state_q <= (x_q == '0 || y_q == '0) ? ST_OUT : ST_GCD;
				end
				ST_GCD: begin
					if (u_q == v_q) state_q <= (g == NW'(1)) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(NW - 1)) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: hw/rtl/rational_number_alu_top.sv
// Channel  Dir  Signals                     Contents (lowest bit first)
// s        in   s_tvalid/s_tready/s_tdata   a_num, a_den, a_empty, b_num, b_den, b_empty
//                 s_tuser                   func
// m        out  m_tvalid/m_tready/m_tdata   res_num, res_den, res_empty, res_flag, res_int
//
// One result per input transfer, in order. The front decodes func and queues the item
// (two entries), so input goes on while the back works or the output stalls, till full.
// Add, mul, the compares and add_reduce use the shared multiplier; make and add_reduce
// may then run the binary GCD loop, one step a cycle, and the restoring divider, one
// quotient bit a cycle over 2*min(VALUE_BITS,16)+1 bits; to_int uses the divider alone.
// arst_n clears the queue pointers, the sequencer and the output valid; no clearing pass.
// m_tdata holds while m_tvalid is high and m_tready low.
module rational_number_alu_top import rna_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS   // 4 .. 32, operands use the low bits
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// [15:0] a_num, [31:16] a_den, [32] a_empty, [48:33] b_num, [64:49] b_den,
	// [65] b_empty, rest zero
	input  logic [IN_TDATA_BITS-1:0]  s_tdata,
	// [2:0] func
	input  logic [FUNC_BITS-1:0]      s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// [32:0] res_num, [64:33] res_den, [65] res_empty, [66] res_flag,
	// [83:67] res_int, rest zero
	output logic [OUT_TDATA_BITS-1:0] m_tdata
);

	cmd_t push_cmd, pop_cmd;
	logic q_push, q_pop, q_full, q_empty;
	res_t res;

	// front: decode and classify
	rna_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	// short queue between front and back
	rna_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	// back: multiply, reduce, divide, register the result
	rna_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (pop_cmd),
		.q_pop     (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {{(OUT_TDATA_BITS - $bits(res_t)){1'b0}}, res};

endmodule

FILE: hw/rtl/rna_checker.sv
module rna_checker import rna_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [OUT_TDATA_BITS-1:0] m_tdata
);

	// stalled transfer stays up
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped under stall");

	// stalled payload holds
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("m_tdata changed under stall");

	// empty fraction carries zero numerator, denominator, flag and int
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[65] |-> m_tdata[64:0] == '0 && m_tdata[83:66] == '0)
		else $error("empty result with nonzero fields");

	// a compare outcome comes alone
	a_flag_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[66] |-> m_tdata[65:0] == '0 && m_tdata[83:67] == '0)
		else $error("compare result with other fields set");

endmodule

bind rational_number_alu_top rna_checker u_rna_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: test/rational_number_alu_top_test.sv
module rational_number_alu_top_test;
	import rna_pkg::*;

	localparam int VALUE_BITS = DEF_VALUE_BITS;

	// func code with no operation behind it; the block answers with all-zero fields
	localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 3'd7;

	// slowest back path: binary GCD plus restoring divider
	localparam int WORST_LATENCY = 6 * VALUE_BITS + 8;
	localparam int DRAIN_CYCLES  = 2 * WORST_LATENCY;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int MAX_PRINTED   = 40;

	// one operation as it goes in on the slave side
	typedef struct {
		logic [FUNC_BITS-1:0]  func;
		logic [FIELD_BITS-1:0] a_num;
		logic [FIELD_BITS-1:0] a_den;
		logic                  a_empty;
		logic [FIELD_BITS-1:0] b_num;
		logic [FIELD_BITS-1:0] b_den;
		logic                  b_empty;
	} fraction_op_t;

	// one result as it comes out on the master side
	typedef struct {
		logic [NUM_BITS-1:0] num;
		logic [DEN_BITS-1:0] den;
		logic                empty;
		logic                flag;
		logic [INT_BITS-1:0] ival;
	} fraction_result_t;

	logic                      clk      = 1'b0;
	logic                      arst_n   = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [IN_TDATA_BITS-1:0]  s_tdata  = '0;  // a_num, a_den, a_empty, b_num, b_den, b_empty
	logic [FUNC_BITS-1:0]      s_tuser  = '0;  // func
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_tdata;        // res_num, res_den, res_empty, res_flag, res_int

	// results owed by the block, oldest first
	fraction_result_t pending_results[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count   = 0;
	int checked_count = 0;
	int cycle_count   = 0;
	int op_count[8]   = '{default: 0};

	rational_number_alu_top #(
		.VALUE_BITS(VALUE_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// cycle watchdog: a hung handshake ends the run here
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still owed", cycle_count,
			pending_results.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic report_error(string msg);
		if (error_count < MAX_PRINTED)
			$display("%0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic longint unsigned common_divisor(longint unsigned x, longint unsigned y);
		longint unsigned t;
		if (x == 0 || y == 0)
			return 1;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// expected result of one operation; all products fit in 64 bits at 16-bit operands
	function automatic fraction_result_t fraction_result(fraction_op_t op);
		fraction_result_t r;
		longint unsigned an, ad, bn, bd, n, d, g;
		logic any_empty;
		logic same;
		r = '{num: '0, den: '0, empty: 1'b0, flag: 1'b0, ival: '0};
		an = op.a_num;
		ad = op.a_den;
		bn = op.b_num;
		bd = op.b_den;
		any_empty = op.a_empty | op.b_empty;
		case (op.func)
			FUNC_MAKE: begin
				// a_empty and the whole second operand play no part here
				if (ad == 0) begin
					r.empty = 1'b1;
				end else begin
					g = common_divisor(an, ad);
					n = an / g;
					d = ad / g;
					r.num = n[NUM_BITS-1:0];
					r.den = d[DEN_BITS-1:0];
				end
			end
			FUNC_ADD, FUNC_ADD_REDUCE: begin
				if (any_empty) begin
					r.empty = 1'b1;
				end else begin
					n = an * bd + ad * bn;
					d = ad * bd;
					if (op.func == FUNC_ADD_REDUCE) begin
						g = common_divisor(n, d);
						n = n / g;
						d = d / g;
					end
					r.num = n[NUM_BITS-1:0];
					r.den = d[DEN_BITS-1:0];
				end
			end
			FUNC_MUL: begin
				if (any_empty) begin
					r.empty = 1'b1;
				end else begin
					n = an * bn;
					d = ad * bd;
					r.num = n[NUM_BITS-1:0];
					r.den = d[DEN_BITS-1:0];
				end
			end
			FUNC_EQUAL, FUNC_NOT_EQUAL: begin
				if (!any_empty) begin
					same = (an * bd) == (ad * bn);
					r.flag = (op.func == FUNC_EQUAL) ? same : !same;
				end
			end
			FUNC_TO_INT: begin
				// only the first operand counts; zero denominator reads as -1 too
				if (op.a_empty || ad == 0) begin
					r.ival = '1;
				end else begin
					n = an / ad;
					r.ival = n[INT_BITS-1:0];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic fraction_op_t fraction_op(logic [FUNC_BITS-1:0] func,
			int a_num, int a_den, logic a_empty, int b_num, int b_den, logic b_empty);
		fraction_op_t op;
		op.func    = func;
		op.a_num   = a_num[FIELD_BITS-1:0];
		op.a_den   = a_den[FIELD_BITS-1:0];
		op.a_empty = a_empty;
		op.b_num   = b_num[FIELD_BITS-1:0];
		op.b_den   = b_den[FIELD_BITS-1:0];
		op.b_empty = b_empty;
		return op;
	endfunction

	// Drives one item from a falling edge and holds it until the transfer happens.
	// Returns just after the accepting rising edge; the next call or the end of
	// stimulus takes s_tvalid from there, so each step sees one assignment at most.
	task automatic send_op(fraction_op_t op);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op.func;
		s_tdata  <= {6'b0, op.b_empty, op.b_den, op.b_num, op.a_empty, op.a_den, op.a_num};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(fraction_result(op));
		op_count[op.func]++;
	endtask

	// receiver side: random back-pressure, decided at the falling edge
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// every master-side transfer is matched against the oldest owed result
	always @(posedge clk) begin : result_check
		fraction_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_error($sformatf("result with nothing owed, tdata %0h", m_tdata));
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (m_tdata[32:0] !== want.num)
					report_error($sformatf("res_num got %0h want %0h",
						m_tdata[32:0], want.num));
				if (m_tdata[64:33] !== want.den)
					report_error($sformatf("res_den got %0h want %0h",
						m_tdata[64:33], want.den));
				if (m_tdata[65] !== want.empty)
					report_error($sformatf("res_empty got %b want %b",
						m_tdata[65], want.empty));
				if (m_tdata[66] !== want.flag)
					report_error($sformatf("res_flag got %b want %b",
						m_tdata[66], want.flag));
				if (m_tdata[83:67] !== want.ival)
					report_error($sformatf("res_int got %0h want %0h",
						m_tdata[83:67], want.ival));
				if (m_tdata[87:84] !== 4'b0)
					report_error($sformatf("tdata pad bits got %b", m_tdata[87:84]));
			end
		end
	end

	// make: zero denominator, zero numerator, common factors, ignored fields
	task automatic test_make();
		send_op(fraction_op(FUNC_MAKE, 0, 0, 1'b0, 0, 1, 1'b0));
		send_op(fraction_op(FUNC_MAKE, 0, 5, 1'b0, 0, 1, 1'b0));
		send_op(fraction_op(FUNC_MAKE, 12, 18, 1'b0, 0, 1, 1'b0));
		send_op(fraction_op(FUNC_MAKE, 65535, 65535, 1'b0, 65535, 65535, 1'b0));
		send_op(fraction_op(FUNC_MAKE, 6, 4, 1'b1, 7, 3, 1'b1));
	endtask

	// add, add_reduce, mul: widest products, empties, zero terms, zero denominator
	task automatic test_add_mul();
		send_op(fraction_op(FUNC_ADD, 1, 2, 1'b0, 1, 3, 1'b0));
		send_op(fraction_op(FUNC_ADD, 65535, 65535, 1'b0, 65535, 65535, 1'b0));
		send_op(fraction_op(FUNC_ADD, 1, 2, 1'b1, 1, 3, 1'b0));
		send_op(fraction_op(FUNC_ADD, 3, 0, 1'b0, 1, 2, 1'b0));
		send_op(fraction_op(FUNC_ADD_REDUCE, 1, 6, 1'b0, 1, 3, 1'b0));
		send_op(fraction_op(FUNC_ADD_REDUCE, 0, 4, 1'b0, 0, 6, 1'b0));
		send_op(fraction_op(FUNC_ADD_REDUCE, 3, 0, 1'b0, 1, 2, 1'b0));
		send_op(fraction_op(FUNC_MUL, 65535, 65535, 1'b0, 65535, 65535, 1'b0));
		send_op(fraction_op(FUNC_MUL, 2, 3, 1'b0, 4, 5, 1'b1));
	endtask

	// equal / not_equal: same value in other terms, different values, empty operand
	task automatic test_compare();
		send_op(fraction_op(FUNC_EQUAL, 1, 2, 1'b0, 2, 4, 1'b0));
		send_op(fraction_op(FUNC_EQUAL, 1, 2, 1'b0, 1, 3, 1'b0));
		send_op(fraction_op(FUNC_EQUAL, 1, 2, 1'b1, 1, 2, 1'b0));
		send_op(fraction_op(FUNC_NOT_EQUAL, 1, 2, 1'b0, 1, 3, 1'b0));
		send_op(fraction_op(FUNC_NOT_EQUAL, 1, 2, 1'b0, 1, 3, 1'b1));
	endtask

	// to_int: largest quotient, truncation, empty and zero-denominator cases;
	// also the unused func code
	task automatic test_to_int();
		send_op(fraction_op(FUNC_TO_INT, 65535, 1, 1'b0, 0, 1, 1'b0));
		send_op(fraction_op(FUNC_TO_INT, 7, 2, 1'b0, 5, 9, 1'b1));
		send_op(fraction_op(FUNC_TO_INT, 7, 2, 1'b1, 5, 9, 1'b0));
		send_op(fraction_op(FUNC_TO_INT, 7, 0, 1'b0, 5, 9, 1'b0));
		send_op(fraction_op(FUNC_UNUSED, 65535, 65535, 1'b0, 65535, 65535, 1'b0));
	endtask

	// operand values weighted toward zero, all-ones and small numbers
	function automatic logic [FIELD_BITS-1:0] random_operand();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return FIELD_BITS'($urandom_range(1, 30));
			default: return FIELD_BITS'($urandom());
		endcase
	endfunction

	function automatic fraction_op_t random_op();
		fraction_op_t op;
		int g;
		int k;
		op.func  = FUNC_BITS'($urandom_range(FUNC_MAKE, FUNC_TO_INT));
		op.a_num = random_operand();
		op.a_den = random_operand();
		// shared factor so that reduction has real work to do
		if ($urandom_range(0, 3) == 0) begin
			g = $urandom_range(2, 200);
			op.a_num = FIELD_BITS'(g * $urandom_range(0, 300));
			op.a_den = FIELD_BITS'(g * $urandom_range(1, 300));
		end
		op.b_num = random_operand();
		op.b_den = random_operand();
		if (op.b_den == 0)
			op.b_den = FIELD_BITS'($urandom_range(1, 65535));
		// comparisons: half the time the second operand is the first one rescaled
		if ((op.func == FUNC_EQUAL || op.func == FUNC_NOT_EQUAL) && $urandom_range(0, 1)) begin
			k = $urandom_range(1, 8);
			if (op.a_den != 0 && op.a_num * k <= 65535 && op.a_den * k <= 65535) begin
				op.b_num = FIELD_BITS'(op.a_num * k);
				op.b_den = FIELD_BITS'(op.a_den * k);
			end
		end
		op.a_empty = ($urandom_range(0, 11) == 0);
		op.b_empty = ($urandom_range(0, 11) == 0);
		return op;
	endfunction

	task automatic test_random(int count, int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count)
			send_op(random_op());
	endtask

	initial begin : stimulus
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed items run with light idling on both sides
		send_idle_pct = 20;
		recv_idle_pct = 20;
		test_make();
		test_add_mul();
		test_compare();
		test_to_int();

		test_random(384, 34, 64);
		test_random(383, 64, 34);
		test_random(383, 0, 0);

		@(negedge clk);
		s_tvalid <= 1'b0;
		recv_idle_pct = 0;

		while (pending_results.size() != 0)
			@(posedge clk);
		// anything arriving now has no owner and is flagged by the checker
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d transfers: make %0d, add %0d, add_reduce %0d, mul %0d,",
			op_count.sum(), op_count[FUNC_MAKE], op_count[FUNC_ADD],
			op_count[FUNC_ADD_REDUCE], op_count[FUNC_MUL]);
		$display("  equal %0d, not_equal %0d, to_int %0d, unused %0d; %0d results checked",
			op_count[FUNC_EQUAL], op_count[FUNC_NOT_EQUAL], op_count[FUNC_TO_INT],
			op_count[FUNC_UNUSED], checked_count);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", error_count);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
